### hdl/cr2a_pkg.sv
package cr2a_pkg;

  localparam int JOBQ_DEPTH_DEF = 4;

  localparam logic [7:0] ESC_CHR   = 8'h1B;
  localparam logic [7:0] ZERO_CHR  = 8'h30;
  localparam logic [7:0] DEF_COLOR = 8'd255;

  typedef struct packed {
    logic            chg;
    logic            bold;
    logic            trail;
    logic [2:0][3:0] fg_dig;
    logic [1:0]      fg_n;
    logic [2:0][3:0] bg_dig;
    logic [1:0]      bg_n;
    logic [2:0][7:0] utf;
    logic [1:0]      utf_n;
  } job_t;

endpackage

### hdl/cr2a_front.sv
module cr2a_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [15:0]        in_char_code,
  input  logic [7:0]         in_fg_index,
  input  logic [7:0]         in_bg_index,
  input  logic               in_bold,
  input  logic               in_end_of_row,
  input  logic               q_full,
  output logic               q_push,
  output cr2a_pkg::job_t     q_job
);
  import cr2a_pkg::*;

  logic [7:0] prev_fg_r, prev_fg_nxt;
  logic [7:0] prev_bg_r, prev_bg_nxt;
  logic       prev_bold_r, prev_bold_nxt;
  logic       chg;

  function automatic job_t put_dec(input job_t j, input logic [7:0] v, input logic is_bg);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [13:0] prod;
    logic [3:0]  t;
    logic [3:0]  o;
    logic [2:0][3:0] d;
    logic [1:0]  n;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - 8'(h) * 8'd100;
    prod = 14'(r[6:0]) * 14'd103;
    t = prod[13:10];
    o = 4'(r - 8'(t) * 8'd10);
    d = '0;
    if (v >= 8'd100) begin
      d[0] = {2'b00, h};
      d[1] = t;
      d[2] = o;
      n = 2'd3;
    end else if (v >= 8'd10) begin
      d[0] = t;
      d[1] = o;
      n = 2'd2;
    end else begin
      d[0] = o;
      n = 2'd1;
    end
    if (is_bg) begin
      j.bg_dig = d;
      j.bg_n = n;
    end else begin
      j.fg_dig = d;
      j.fg_n = n;
    end
    return j;
  endfunction

  assign in_full = q_full;
  assign q_push  = in_push & ~q_full;
  assign chg = (in_fg_index != prev_fg_r) || (in_bg_index != prev_bg_r) ||
               (in_bold != prev_bold_r);

  always_comb begin
    job_t j;
    j = '0;
    j.chg  = chg;
    j.bold = in_bold;
    j = put_dec(j, in_fg_index, 1'b0);
    j = put_dec(j, in_bg_index, 1'b1);
    if (in_char_code < 16'h0080) begin
      j.utf[0] = in_char_code[7:0];
      j.utf_n  = 2'd1;
    end else if (in_char_code < 16'h0800) begin
      j.utf[0] = 8'hC0 | {3'b000, in_char_code[10:6]};
      j.utf[1] = 8'h80 | {2'b00, in_char_code[5:0]};
      j.utf_n  = 2'd2;
    end else begin
      j.utf[0] = 8'hE0 | {4'h0, in_char_code[15:12]};
      j.utf[1] = 8'h80 | {2'b00, in_char_code[11:6]};
      j.utf[2] = 8'h80 | {2'b00, in_char_code[5:0]};
      j.utf_n  = 2'd3;
    end
    prev_fg_nxt   = chg ? in_fg_index : prev_fg_r;
    prev_bg_nxt   = chg ? in_bg_index : prev_bg_r;
    prev_bold_nxt = chg ? in_bold : prev_bold_r;
    j.trail = in_end_of_row &&
              ((prev_fg_nxt != DEF_COLOR) || (prev_bg_nxt != 8'd0) || prev_bold_nxt);
    if (in_end_of_row) begin
      prev_fg_nxt   = DEF_COLOR;
      prev_bg_nxt   = DEF_COLOR;
      prev_bold_nxt = 1'b0;
    end
    q_job = j;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_fg_r   <= DEF_COLOR;
      prev_bg_r   <= DEF_COLOR;
      prev_bold_r <= 1'b0;
    end else if (q_push) begin
      prev_fg_r   <= prev_fg_nxt;
      prev_bg_r   <= prev_bg_nxt;
      prev_bold_r <= prev_bold_nxt;
    end
  end

endmodule

### hdl/cr2a_jobq.sv
module cr2a_jobq #(
  parameter int DEPTH = cr2a_pkg::JOBQ_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cr2a_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output cr2a_pkg::job_t head_job,
  output logic           empty
);
  import cr2a_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  job_t          entries_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full     = (cnt_r == DEPTH_C);
  assign empty    = (cnt_r == '0);
  assign do_push  = push & ~full;
  assign do_pop   = pop & ~empty;
  assign head_job = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

### hdl/cr2a_back.sv
module cr2a_back (
  input  logic           clk,
  input  logic           rst_n,
  input  cr2a_pkg::job_t job,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_byte,
  output logic           out_last_in_run
);
  import cr2a_pkg::*;

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b0000000001,
    PH_PRE   = 10'b0000000010,
    PH_BOLD  = 10'b0000000100,
    PH_FGPRE = 10'b0000001000,
    PH_FG    = 10'b0000010000,
    PH_BGPRE = 10'b0000100000,
    PH_BG    = 10'b0001000000,
    PH_M     = 10'b0010000000,
    PH_UTF   = 10'b0100000000,
    PH_TRL   = 10'b1000000000
  } phase_t;

  phase_t     phase_r, cur, nxt_ph;
  logic [2:0] idx_r;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [7:0] byte_c;
  logic       end_c, last_c;
  logic       advance, emit;

  function automatic logic [7:0] dig_chr(input logic [2:0][3:0] d, input logic [2:0] i);
    logic [3:0] v;
    case (i)
      3'd0:    v = d[0];
      3'd1:    v = d[1];
      default: v = d[2];
    endcase
    return ZERO_CHR + {4'h0, v};
  endfunction

  assign cur = (phase_r == PH_IDLE) ? (job.chg ? PH_PRE : PH_UTF) : phase_r;

  always_comb begin
    byte_c = 8'h00;
    end_c  = 1'b1;
    last_c = 1'b0;
    nxt_ph = PH_IDLE;
    unique case (cur)
      PH_PRE: begin
        case (idx_r)
          3'd0:    byte_c = ESC_CHR;
          3'd1:    byte_c = "[";
          3'd2:    byte_c = "0";
          default: byte_c = ";";
        endcase
        end_c  = (idx_r == 3'd3);
        nxt_ph = job.bold ? PH_BOLD : PH_FGPRE;
      end
      PH_BOLD: begin
        byte_c = (idx_r == 3'd0) ? "1" : ";";
        end_c  = (idx_r == 3'd1);
        nxt_ph = PH_FGPRE;
      end
      PH_FGPRE: begin
        case (idx_r)
          3'd0:    byte_c = "3";
          3'd1:    byte_c = "8";
          3'd3:    byte_c = "5";
          default: byte_c = ";";
        endcase
        end_c  = (idx_r == 3'd4);
        nxt_ph = PH_FG;
      end
      PH_FG: begin
        byte_c = dig_chr(job.fg_dig, idx_r);
        end_c  = (idx_r == {1'b0, job.fg_n - 2'd1});
        nxt_ph = PH_BGPRE;
      end
      PH_BGPRE: begin
        case (idx_r)
          3'd1:    byte_c = "4";
          3'd2:    byte_c = "8";
          3'd4:    byte_c = "5";
          default: byte_c = ";";
        endcase
        end_c  = (idx_r == 3'd5);
        nxt_ph = PH_BG;
      end
      PH_BG: begin
        byte_c = dig_chr(job.bg_dig, idx_r);
        end_c  = (idx_r == {1'b0, job.bg_n - 2'd1});
        nxt_ph = PH_M;
      end
      PH_M: begin
        byte_c = "m";
        nxt_ph = PH_UTF;
      end
      PH_UTF: begin
        case (idx_r)
          3'd0:    byte_c = job.utf[0];
          3'd1:    byte_c = job.utf[1];
          default: byte_c = job.utf[2];
        endcase
        end_c  = (idx_r == {1'b0, job.utf_n - 2'd1});
        nxt_ph = job.trail ? PH_TRL : PH_IDLE;
        last_c = end_c & ~job.trail;
      end
      PH_TRL: begin
        case (idx_r)
          3'd0:    byte_c = ESC_CHR;
          3'd1:    byte_c = "[";
          3'd2:    byte_c = "0";
          default: byte_c = "m";
        endcase
        end_c  = (idx_r == 3'd3);
        last_c = end_c;
      end
      default: begin
        byte_c = 8'h00;
      end
    endcase
  end

  assign advance         = ~out_valid_r | out_pop;
  assign emit            = advance & ~q_empty;
  assign q_pop           = emit & last_c;
  assign out_empty       = ~out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_in_run = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        phase_r     <= end_c ? nxt_ph : cur;
        idx_r       <= end_c ? 3'd0 : idx_r + 3'd1;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_c;
      out_last_r <= last_c;
    end
  end

endmodule

### hdl/cell_row_to_ansi_sgr_utf8.sv
// Terminal row encoder: cells in, ANSI SGR escape and UTF-8 bytes out.
// Input queue side: drive the cell on in_* and raise in_push; the cell is
// taken at a clock edge where in_push is high and in_full is low.
// Result queue side: while out_empty is low, out_byte/out_last_in_run hold
// the oldest byte; it is taken at an edge where out_pop is high.
// out_last_in_run marks the final byte produced by one cell.
// A cell whose attributes differ from the previous cell's (the defaults after reset or a row end)
// produces an SGR sequence before its character; the last cell of a row may add ESC[0m.
// When idle, the first byte of a cell passes through the job queue and the output register to out_*.
// Throughput: one output byte per cycle while out_pop keeps up, set by the single byte
// sequencer; a cell produces 1 to 31 bytes (1 to 3 for plain characters).
// The front stage classifies and encodes cells into a job queue of
// JOBQ_DEPTH entries, so pushes continue while the output side stalls;
// in_full rises only once that queue is full.
// Reset (rst_n low, synchronous) empties both queues and sets the
// attribute history to fg 255, bg 255, not bold.
module cell_row_to_ansi_sgr_utf8 #(
  parameter int JOBQ_DEPTH = cr2a_pkg::JOBQ_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_char_code,
  input  logic [7:0]  in_fg_index,
  input  logic [7:0]  in_bg_index,
  input  logic        in_bold,
  input  logic        in_end_of_row,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_last_in_run
);
  import cr2a_pkg::*;

  job_t push_job, head_job;
  logic q_push, q_full, q_pop, q_empty;

  cr2a_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_char_code  (in_char_code),
    .in_fg_index   (in_fg_index),
    .in_bg_index   (in_bg_index),
    .in_bold       (in_bold),
    .in_end_of_row (in_end_of_row),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  cr2a_jobq #(
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty)
  );

  cr2a_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job             (head_job),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_last_in_run (out_last_in_run)
  );

endmodule

### dv/cell_row_to_ansi_sgr_utf8_tb.sv
`timescale 1ns / 1ps

module cell_row_to_ansi_sgr_utf8_tb;

  localparam logic [7:0] ESC_BYTE   = 8'h1B;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DEF_COLOR  = 8'd255;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [15:0] ch;
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic        bold;
    logic        eor;
  } cell_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } out_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_char_code = '0;
  logic [7:0]  in_fg_index = '0;
  logic [7:0]  in_bg_index = '0;
  logic        in_bold = 1'b0;
  logic        in_end_of_row = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_in_run;

  cell_t      pending_cells[$];
  out_rec_t   want_bytes[$];
  logic [7:0] run_buf[$];

  logic [7:0] hist_fg = DEF_COLOR;
  logic [7:0] hist_bg = DEF_COLOR;
  logic       hist_bold = 1'b0;

  int cells_queued = 0;
  int cells_accepted = 0;
  int bytes_checked = 0;
  int rows_done = 0;
  int sgr_emitted = 0;
  int trailers_skipped = 0;
  int errors = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req_cnt = 0;
  int hold_ack_cnt = 0;
  int hold_left = 0;

  cell_row_to_ansi_sgr_utf8 DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_char_code   (in_char_code),
    .in_fg_index    (in_fg_index),
    .in_bg_index    (in_bg_index),
    .in_bold        (in_bold),
    .in_end_of_row  (in_end_of_row),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_last_in_run(out_last_in_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      run_buf.push_back(8'(s[i]));
    end
  endtask

  task automatic put_decimal(input logic [7:0] v);
    if (v >= 8'd100) begin
      run_buf.push_back(DIGIT_ZERO + v / 8'd100);
    end
    if (v >= 8'd10) begin
      run_buf.push_back(DIGIT_ZERO + (v / 8'd10) % 8'd10);
    end
    run_buf.push_back(DIGIT_ZERO + v % 8'd10);
  endtask

  task automatic encode_cell(input logic [15:0] ch, input logic [7:0] fg,
                             input logic [7:0] bg, input logic bd, input logic eor);
    out_rec_t r;
    run_buf.delete();
    if (fg != hist_fg || bg != hist_bg || bd != hist_bold) begin
      run_buf.push_back(ESC_BYTE);
      put_text("[0;");
      if (bd) begin
        put_text("1;");
      end
      put_text("38;5;");
      put_decimal(fg);
      put_text(";48;5;");
      put_decimal(bg);
      put_text("m");
      hist_fg = fg;
      hist_bg = bg;
      hist_bold = bd;
      sgr_emitted++;
    end
    if (ch < 16'h0080) begin
      run_buf.push_back(ch[7:0]);
    end else if (ch < 16'h0800) begin
      run_buf.push_back({3'b110, ch[10:6]});
      run_buf.push_back({2'b10, ch[5:0]});
    end else begin
      run_buf.push_back({4'b1110, ch[15:12]});
      run_buf.push_back({2'b10, ch[11:6]});
      run_buf.push_back({2'b10, ch[5:0]});
    end
    if (eor) begin
      if (hist_fg != DEF_COLOR || hist_bg != 8'd0 || hist_bold) begin
        run_buf.push_back(ESC_BYTE);
        put_text("[0m");
      end else begin
        trailers_skipped++;
      end
      hist_fg = DEF_COLOR;
      hist_bg = DEF_COLOR;
      hist_bold = 1'b0;
      rows_done++;
    end
    for (int i = 0; i < run_buf.size(); i++) begin
      r.data = run_buf[i];
      r.last = (i == run_buf.size() - 1);
      want_bytes.push_back(r);
    end
  endtask

  always @(posedge clk) begin : drive_cells
    cell_t c;
    if (rst_n) begin
      if (in_push && !in_full) begin
        encode_cell(in_char_code, in_fg_index, in_bg_index, in_bold, in_end_of_row);
        cells_accepted++;
      end
      if (!in_push || !in_full) begin
        if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cells.pop_front();
          in_char_code  <= c.ch;
          in_fg_index   <= c.fg;
          in_bg_index   <= c.bg;
          in_bold       <= c.bold;
          in_end_of_row <= c.eor;
          in_push       <= 1'b1;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_bytes
    out_rec_t w;
    logic pop_nxt;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        bytes_checked++;
        if (want_bytes.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual %02h last %0b",
                   $time, out_byte, out_last_in_run);
          errors++;
        end else begin
          w = want_bytes.pop_front();
          if (out_byte !== w.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, w.data, out_byte);
            errors++;
          end
          if (out_last_in_run !== w.last) begin
            $display("%0t: out_last_in_run mismatch: expected %0b, actual %0b",
                     $time, w.last, out_last_in_run);
            errors++;
          end
        end
      end
      if (hold_req_cnt != hold_ack_cnt) begin
        hold_ack_cnt = hold_req_cnt;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop_nxt = 1'b0;
      end else begin
        pop_nxt = ($urandom_range(99) >= recv_stall_pct);
      end
      out_pop <= pop_nxt;
    end
  end

  task automatic add_cell(input logic [15:0] ch, input logic [7:0] fg, input logic [7:0] bg,
                          input logic bd, input logic eor);
    cell_t c;
    c.ch = ch;
    c.fg = fg;
    c.bg = bg;
    c.bold = bd;
    c.eor = eor;
    pending_cells.push_back(c);
    cells_queued++;
  endtask

  function automatic logic [7:0] pick_color();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd9;
      3: return 8'd10;
      4: return 8'd99;
      5: return 8'd100;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_char();
    case ($urandom_range(7))
      0, 1: return 16'($urandom_range(16'h007F));
      2: return 16'($urandom_range(16'h07FF, 16'h0080));
      3: return 16'($urandom_range(16'hFFFF, 16'h0800));
      4: return 16'($urandom_range(16'hDFFF, 16'hD800));
      5: begin
        case ($urandom_range(5))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          default: return 16'hFFFF;
        endcase
      end
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic cell_t with_attrs(input cell_t c);
    cell_t r;
    r = c;
    case ($urandom_range(9))
      0, 1: begin
        r.fg = DEF_COLOR;
        r.bg = 8'd0;
        r.bold = 1'b0;
      end
      2: begin
        r.fg = DEF_COLOR;
        r.bg = DEF_COLOR;
        r.bold = 1'b0;
      end
      default: begin
        r.fg = pick_color();
        r.bg = pick_color();
        r.bold = 1'($urandom_range(1));
      end
    endcase
    return r;
  endfunction

  task automatic add_random_cells(input int n);
    cell_t c;
    int row_left;
    row_left = 0;
    c.ch = '0;
    c.fg = DEF_COLOR;
    c.bg = DEF_COLOR;
    c.bold = 1'b0;
    c.eor = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (row_left == 0) begin
        row_left = $urandom_range(8, 1);
        c = with_attrs(c);
      end else if ($urandom_range(99) < 30) begin
        c = with_attrs(c);
      end
      c.ch = pick_char();
      row_left--;
      c.eor = (row_left == 0);
      if ($urandom_range(99) < 12) begin
        c.ch = 16'($urandom_range(16'hFFFF));
        c.fg = 8'($urandom_range(255));
        c.bg = 8'($urandom_range(255));
        c.bold = 1'($urandom_range(1));
        c.eor = 1'($urandom_range(1));
        if (c.eor) begin
          row_left = 0;
        end
      end
      add_cell(c.ch, c.fg, c.bg, c.bold, c.eor);
    end
  endtask

  task automatic wait_drained();
    while (cells_accepted != cells_queued || want_bytes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_cell(16'h0041, 8'd255, 8'd255, 1'b0, 1'b0);
    add_cell(16'h007F, 8'd255, 8'd255, 1'b0, 1'b0);
    add_cell(16'h0080, 8'd0,   8'd0,   1'b0, 1'b0);
    add_cell(16'h07FF, 8'd9,   8'd10,  1'b1, 1'b0);
    add_cell(16'h0800, 8'd99,  8'd100, 1'b1, 1'b0);
    add_cell(16'hD800, 8'd99,  8'd100, 1'b1, 1'b0);
    add_cell(16'hDFFF, 8'd255, 8'd0,   1'b0, 1'b1);
    add_cell(16'hFFFF, 8'd255, 8'd0,   1'b0, 1'b1);
    add_cell(16'h0000, 8'd255, 8'd255, 1'b0, 1'b1);
    add_cell(16'h0041, 8'd255, 8'd0,   1'b1, 1'b1);
    add_cell(16'h0042, 8'd0,   8'd255, 1'b0, 1'b0);
    add_cell(16'h0043, 8'd0,   8'd255, 1'b0, 1'b1);
    add_cell(16'h20AC, 8'd1,   8'd2,   1'b0, 1'b1);
    add_cell(16'h0000, 8'd255, 8'd0,   1'b0, 1'b0);
    add_cell(16'h007E, 8'd255, 8'd0,   1'b0, 1'b1);
    add_cell(16'h5555, 8'd170, 8'd85,  1'b1, 1'b0);
    add_cell(16'hAAAA, 8'd85,  8'd170, 1'b0, 1'b1);
    wait_drained();

    add_random_cells(40);
    wait_drained();
    add_random_cells(40);
    wait_drained();

    send_idle_pct = 47;
    add_random_cells(60);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 47;
    hold_req_cnt++;
    add_random_cells(80);
    wait_drained();

    send_idle_pct = 26;
    recv_stall_pct = 26;
    add_random_cells(80);
    wait_drained();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random_cells(20);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d cells in %0d rows, %0d bytes checked, %0d SGR sequences.",
             cells_accepted, rows_done, bytes_checked, sgr_emitted);
    $display("Row-end resets skipped %0d times; idle, stall and full-queue phases run.",
             trailers_skipped);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
